// ===== hw/rtl/stlp_pkg.sv =====
`timescale 1ns / 1ps
package stlp_pkg;

    localparam int STLP_HOUR_DIGITS = 6;
    localparam int CHAR_W           = 8;
    localparam int TIME_W           = 42;
    localparam int MIN_W            = 7;
    localparam int SEC_W            = 7;
    localparam int MS_W             = 10;
    localparam int OUT_DATA_W       = 96;

    localparam logic [TIME_W-1:0] MS_PER_HOUR = TIME_W'(3600000);
    localparam logic [TIME_W-1:0] MS_PER_MIN  = TIME_W'(60000);
    localparam logic [TIME_W-1:0] MS_PER_SEC  = TIME_W'(1000);

    localparam logic [CHAR_W-1:0] CH_SPACE = 8'h20;
    localparam logic [CHAR_W-1:0] CH_TAB   = 8'h09;
    localparam logic [CHAR_W-1:0] CH_ZERO  = 8'h30;
    localparam logic [CHAR_W-1:0] CH_NINE  = 8'h39;
    localparam logic [CHAR_W-1:0] CH_COLON = 8'h3A;
    localparam logic [CHAR_W-1:0] CH_COMMA = 8'h2C;
    localparam logic [CHAR_W-1:0] CH_DOT   = 8'h2E;
    localparam logic [CHAR_W-1:0] CH_DASH  = 8'h2D;
    localparam logic [CHAR_W-1:0] CH_GT    = 8'h3E;

    typedef enum logic [4:0] {
        PH_LEAD        = 5'd0,
        PH_HOURS       = 5'd1,
        PH_MIN         = 5'd2,
        PH_COLON2      = 5'd3,
        PH_SEC         = 5'd4,
        PH_SEP         = 5'd5,
        PH_MS          = 5'd6,
        PH_ARROW_BLANK = 5'd7,
        PH_ARROW1      = 5'd8,
        PH_ARROW2      = 5'd9,
        PH_E_LEAD      = 5'd10,
        PH_E_HOURS     = 5'd11,
        PH_E_MIN       = 5'd12,
        PH_E_COLON2    = 5'd13,
        PH_E_SEC       = 5'd14,
        PH_E_SEP       = 5'd15,
        PH_E_MS        = 5'd16,
        PH_TRAIL       = 5'd17
    } t_phase;

    typedef enum logic [2:0] {
        ST_OK        = 3'd0,
        ST_BAD_START = 3'd1,
        ST_NO_ARROW  = 3'd2,
        ST_BAD_END   = 3'd3,
        ST_TRAIL     = 3'd4
    } t_status;

    typedef enum logic [2:0] {
        DT_NONE   = 3'd0,
        DT_HOURS  = 3'd1,
        DT_COLON1 = 3'd2,
        DT_MIN    = 3'd3,
        DT_COLON2 = 3'd4,
        DT_SEC    = 3'd5,
        DT_SEP    = 3'd6,
        DT_MS     = 3'd7
    } t_detail;

    typedef struct packed {
        logic              valid;
        logic              last;
        logic [CHAR_W-1:0] code;
    } t_beat;

    typedef struct packed {
        t_detail           detail;
        t_status           status;
        logic [TIME_W-1:0] end_ms;
        logic [TIME_W-1:0] start_ms;
    } t_result;

endpackage

// ===== hw/rtl/stlp_in_reg.sv =====
`timescale 1ns / 1ps
module stlp_in_reg
    import stlp_pkg::*;
(
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_valid,
    output logic              o_ready,
    input  logic [CHAR_W-1:0] i_code,
    input  logic              i_last,
    input  logic              i_take,
    output t_beat             o_beat
);

    logic              r_valid;
    logic              r_last;
    logic [CHAR_W-1:0] r_code;

    assign o_ready = !r_valid || i_take;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (o_ready) begin
            r_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_ready && i_valid) begin
            r_code <= i_code;
            r_last <= i_last;
        end
    end

    assign o_beat.valid = r_valid;
    assign o_beat.last  = r_last;
    assign o_beat.code  = r_code;

endmodule

// ===== hw/rtl/stlp_parse.sv =====
`timescale 1ns / 1ps
module stlp_parse
    import stlp_pkg::*;
#(
    parameter int HOUR_DIGITS = STLP_HOUR_DIGITS
) (
    input  logic    i_clk,
    input  logic    i_rst_n,
    input  t_beat   i_beat,
    output logic    o_take,
    output logic    o_valid,
    input  logic    i_ready,
    output t_result o_result
);

    localparam int HW      = $clog2(10 ** HOUR_DIGITS);
    localparam int DCW_RAW = $clog2(HOUR_DIGITS + 1);
    localparam int DCW     = (DCW_RAW < 2) ? 2 : DCW_RAW;
    localparam int DC_MAX  = (HOUR_DIGITS < 2) ? 2 : HOUR_DIGITS;

    t_phase            r_phase, n_phase;
    logic [DCW-1:0]    r_dcnt, n_dcnt;
    logic [HW-1:0]     r_hours, n_hours;
    logic [MIN_W-1:0]  r_min, n_min;
    logic [SEC_W-1:0]  r_sec, n_sec;
    logic [MS_W-1:0]   r_ms, n_ms;
    logic [TIME_W-1:0] r_start;
    t_status           r_st, n_st;
    t_detail           r_dt, n_dt;
    logic              r_out_valid;
    t_result           r_out;

    logic              v_is_end;
    t_status           v_bad;
    logic              v_blank;
    logic              v_digit;
    logic [3:0]        v_d;
    logic [TIME_W-1:0] v_total;
    logic              v_byte;
    logic              v_eol;
    t_status           v_fin_st;
    t_detail           v_fin_dt;

    assign o_take = i_beat.valid && (!i_beat.last || !r_out_valid || i_ready);
    assign v_byte = o_take && !i_beat.last;
    assign v_eol  = o_take && i_beat.last;

    assign v_blank = (i_beat.code == CH_SPACE) || (i_beat.code == CH_TAB);
    assign v_digit = (i_beat.code >= CH_ZERO) && (i_beat.code <= CH_NINE);
    assign v_d     = 4'(i_beat.code - CH_ZERO);

    assign v_total = TIME_W'(TIME_W'(r_hours) * MS_PER_HOUR)
                   + TIME_W'(TIME_W'(r_min) * MS_PER_MIN)
                   + TIME_W'(TIME_W'(r_sec) * MS_PER_SEC)
                   + TIME_W'(r_ms);

    always_comb begin
        n_phase  = r_phase;
        n_dcnt   = r_dcnt;
        n_hours  = r_hours;
        n_min    = r_min;
        n_sec    = r_sec;
        n_ms     = r_ms;
        n_st     = r_st;
        n_dt     = r_dt;
        v_is_end = (r_phase >= PH_E_LEAD) && (r_phase != PH_TRAIL);
        v_bad    = v_is_end ? ST_BAD_END : ST_BAD_START;
        if (r_st == ST_OK) begin
            case (r_phase)
                PH_LEAD, PH_E_LEAD: begin
                    if (!v_blank) begin
                        if (!v_digit) begin
                            n_st = v_bad;
                            n_dt = DT_HOURS;
                        end else begin
                            n_hours = HW'(v_d);
                            n_min   = '0;
                            n_sec   = '0;
                            n_ms    = '0;
                            n_dcnt  = DCW'(1);
                            n_phase = v_is_end ? PH_E_HOURS : PH_HOURS;
                        end
                    end
                end
                PH_HOURS, PH_E_HOURS: begin
                    if (v_digit && (r_dcnt < DCW'(HOUR_DIGITS))) begin
                        n_hours = HW'(r_hours * HW'(10)) + HW'(v_d);
                        n_dcnt  = r_dcnt + DCW'(1);
                    end else if (i_beat.code == CH_COLON) begin
                        n_dcnt  = '0;
                        n_phase = v_is_end ? PH_E_MIN : PH_MIN;
                    end else begin
                        n_st = v_bad;
                        n_dt = DT_COLON1;
                    end
                end
                PH_MIN, PH_E_MIN: begin
                    if (!v_digit) begin
                        n_st = v_bad;
                        n_dt = DT_MIN;
                    end else begin
                        n_min = MIN_W'(r_min * MIN_W'(10)) + MIN_W'(v_d);
                        if (r_dcnt != '0) begin
                            n_dcnt  = '0;
                            n_phase = v_is_end ? PH_E_COLON2 : PH_COLON2;
                        end else begin
                            n_dcnt = DCW'(1);
                        end
                    end
                end
                PH_COLON2, PH_E_COLON2: begin
                    if (i_beat.code == CH_COLON) begin
                        n_phase = v_is_end ? PH_E_SEC : PH_SEC;
                    end else begin
                        n_st = v_bad;
                        n_dt = DT_COLON2;
                    end
                end
                PH_SEC, PH_E_SEC: begin
                    if (!v_digit) begin
                        n_st = v_bad;
                        n_dt = DT_SEC;
                    end else begin
                        n_sec = SEC_W'(r_sec * SEC_W'(10)) + SEC_W'(v_d);
                        if (r_dcnt != '0) begin
                            n_dcnt  = '0;
                            n_phase = v_is_end ? PH_E_SEP : PH_SEP;
                        end else begin
                            n_dcnt = DCW'(1);
                        end
                    end
                end
                PH_SEP, PH_E_SEP: begin
                    if ((i_beat.code == CH_COMMA) || (i_beat.code == CH_DOT)) begin
                        n_dcnt  = '0;
                        n_phase = v_is_end ? PH_E_MS : PH_MS;
                    end else begin
                        n_st = v_bad;
                        n_dt = DT_SEP;
                    end
                end
                PH_MS, PH_E_MS: begin
                    if (!v_digit) begin
                        n_st = v_bad;
                        n_dt = DT_MS;
                    end else begin
                        n_ms = MS_W'(r_ms * MS_W'(10)) + MS_W'(v_d);
                        if (r_dcnt >= DCW'(2)) begin
                            n_dcnt  = '0;
                            n_phase = v_is_end ? PH_TRAIL : PH_ARROW_BLANK;
                        end else begin
                            n_dcnt = r_dcnt + DCW'(1);
                        end
                    end
                end
                PH_ARROW_BLANK: begin
                    if (!v_blank) begin
                        if (i_beat.code == CH_DASH) begin
                            n_phase = PH_ARROW1;
                        end else begin
                            n_st = ST_NO_ARROW;
                            n_dt = DT_NONE;
                        end
                    end
                end
                PH_ARROW1: begin
                    if (i_beat.code == CH_DASH) begin
                        n_phase = PH_ARROW2;
                    end else begin
                        n_st = ST_NO_ARROW;
                        n_dt = DT_NONE;
                    end
                end
                PH_ARROW2: begin
                    if (i_beat.code == CH_GT) begin
                        n_phase = PH_E_LEAD;
                    end else begin
                        n_st = ST_NO_ARROW;
                        n_dt = DT_NONE;
                    end
                end
                PH_TRAIL: begin
                    if (!v_blank) begin
                        n_st = ST_TRAIL;
                        n_dt = DT_NONE;
                    end
                end
                default: begin
                    n_st = ST_NO_ARROW;
                    n_dt = DT_NONE;
                end
            endcase
        end
    end

    always_comb begin
        v_fin_st = r_st;
        v_fin_dt = r_dt;
        if (r_st == ST_OK) begin
            case (r_phase)
                PH_LEAD, PH_E_LEAD: v_fin_dt = DT_HOURS;
                PH_HOURS, PH_E_HOURS: v_fin_dt = DT_COLON1;
                PH_MIN, PH_E_MIN: v_fin_dt = DT_MIN;
                PH_COLON2, PH_E_COLON2: v_fin_dt = DT_COLON2;
                PH_SEC, PH_E_SEC: v_fin_dt = DT_SEC;
                PH_SEP, PH_E_SEP: v_fin_dt = DT_SEP;
                PH_MS, PH_E_MS: v_fin_dt = DT_MS;
                default: v_fin_dt = DT_NONE;
            endcase
            case (r_phase)
                PH_TRAIL: v_fin_st = ST_OK;
                PH_ARROW_BLANK, PH_ARROW1, PH_ARROW2: v_fin_st = ST_NO_ARROW;
                default: v_fin_st = v_bad;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase <= PH_LEAD;
            r_dcnt  <= '0;
            r_hours <= '0;
            r_min   <= '0;
            r_sec   <= '0;
            r_ms    <= '0;
            r_start <= '0;
            r_st    <= ST_OK;
            r_dt    <= DT_NONE;
        end else if (v_eol) begin
            r_phase <= PH_LEAD;
            r_dcnt  <= '0;
            r_hours <= '0;
            r_min   <= '0;
            r_sec   <= '0;
            r_ms    <= '0;
            r_start <= '0;
            r_st    <= ST_OK;
            r_dt    <= DT_NONE;
        end else if (v_byte) begin
            r_phase <= n_phase;
            r_dcnt  <= n_dcnt;
            r_hours <= n_hours;
            r_min   <= n_min;
            r_sec   <= n_sec;
            r_ms    <= n_ms;
            r_st    <= n_st;
            r_dt    <= n_dt;
            if (r_phase == PH_ARROW_BLANK) begin
                r_start <= v_total;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (v_eol) begin
            r_out_valid <= 1'b1;
        end else if (i_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (v_eol) begin
            r_out.status   <= v_fin_st;
            r_out.detail   <= v_fin_dt;
            r_out.start_ms <= (v_fin_st == ST_OK) ? r_start : '0;
            r_out.end_ms   <= (v_fin_st == ST_OK) ? v_total : '0;
        end
    end

    assign o_valid  = r_out_valid;
    assign o_result = r_out;

    a_err_zero_times : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_valid && (r_out.status != ST_OK) |-> (r_out.start_ms == '0) && (r_out.end_ms == '0))
        else $error("times not cleared on error result");

    a_detail_kind : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_valid && ((r_out.status == ST_OK) || (r_out.status == ST_NO_ARROW)
        || (r_out.status == ST_TRAIL)) |-> (r_out.detail == DT_NONE))
        else $error("detail set for a status that carries none");

    a_err_freezes : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_st != ST_OK) && !v_eol |=> $stable(r_phase) && $stable(r_st) && $stable(r_dt))
        else $error("parser moved after first error");

    a_dcnt_range : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_dcnt <= DCW'(DC_MAX))
        else $error("digit count out of range");

    a_eol_clears : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        v_eol |=> (r_phase == PH_LEAD) && (r_st == ST_OK) && r_out_valid)
        else $error("line end did not emit and clear");

endmodule

// ===== hw/rtl/subtitle_timing_line_parser_top.sv =====
`timescale 1ns / 1ps
// Timing line parser: takes one byte of a subtitle timing line per beat and
// returns start and end times in milliseconds, a status and a detail code on
// the beat that carries tlast. Every beat goes through one input register and
// a single pass of phase and digit logic, so one beat is taken each cycle, and the
// result is registered; an end-of-line beat waits only while the result register
// still holds an untaken result.
module subtitle_timing_line_parser_top
    import stlp_pkg::*;
#(
    parameter int HOUR_DIGITS = STLP_HOUR_DIGITS
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  s_axis_tvalid,
    output logic                  s_axis_tready,
    input  logic [CHAR_W-1:0]     s_axis_tdata,  // [7:0] char_code
    input  logic                  s_axis_tlast,
    output logic                  m_axis_tvalid,
    input  logic                  m_axis_tready,
    output logic [OUT_DATA_W-1:0] m_axis_tdata   // [41:0] start_ms, [83:42] end_ms,
                                                 // [86:84] status, [89:87] detail
);

    t_beat   w_beat;
    logic    w_take;
    t_result w_result;

    stlp_in_reg u_in_reg (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (s_axis_tvalid),
        .o_ready (s_axis_tready),
        .i_code  (s_axis_tdata),
        .i_last  (s_axis_tlast),
        .i_take  (w_take),
        .o_beat  (w_beat)
    );

    stlp_parse #(
        .HOUR_DIGITS (HOUR_DIGITS)
    ) u_parse (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_beat   (w_beat),
        .o_take   (w_take),
        .o_valid  (m_axis_tvalid),
        .i_ready  (m_axis_tready),
        .o_result (w_result)
    );

    assign m_axis_tdata = {(OUT_DATA_W - $bits(t_result))'(0), w_result};

endmodule

// ===== tb/subtitle_timing_line_parser_top_test.sv =====
`timescale 1ns / 1ps
module subtitle_timing_line_parser_top_test;
    import stlp_pkg::*;

    localparam int IDLE_LIMIT  = 2000;
    localparam int DRAIN_WAIT  = 20;
    localparam int GOOD_BEATS  = 1100;
    localparam int TOTAL_BEATS = 1650;

    logic                  i_clk         = 1'b0;
    logic                  i_rst_n       = 1'b0;
    logic                  s_axis_tvalid = 1'b0;
    logic                  s_axis_tready;
    logic [CHAR_W-1:0]     s_axis_tdata  = '0;   // [7:0] char_code
    logic                  s_axis_tlast  = 1'b0;
    logic                  m_axis_tvalid;
    logic                  m_axis_tready = 1'b0;
    logic [OUT_DATA_W-1:0] m_axis_tdata;         // [41:0] start_ms, [83:42] end_ms,
                                                 // [86:84] status, [89:87] detail

    subtitle_timing_line_parser_top u_dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tlast  (s_axis_tlast),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata)
    );

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    // line parser state as seen from outside
    t_phase             cur_phase;
    logic [2:0]         digit_cnt;
    logic [19:0]        hrs;
    logic [MIN_W-1:0]   mins;
    logic [SEC_W-1:0]   secs;
    logic [MS_W-1:0]    msecs;
    logic [TIME_W-1:0]  start_total_ms;
    t_status            first_status;
    t_detail            first_detail;

    t_result            timing_results_q[$];
    logic [CHAR_W-1:0]  line_buf[$];

    int fail_count  = 0;
    int beats_sent  = 0;
    int burst_left  = 0;
    int idle_cycles = 0;
    int rx_tick     = 0;
    int rx_mode     = 0;

    function automatic void clear_line();
        cur_phase      = PH_LEAD;
        digit_cnt      = '0;
        hrs            = '0;
        mins           = '0;
        secs           = '0;
        msecs          = '0;
        start_total_ms = '0;
        first_status   = ST_OK;
        first_detail   = DT_NONE;
    endfunction

    function automatic void note_error(input t_status st, input t_detail dt);
        first_status = st;
        first_detail = dt;
    endfunction

    function automatic logic [TIME_W-1:0] line_total_ms();
        logic [63:0] acc;
        acc = 64'(hrs) * 64'd60 + 64'(mins);
        acc = acc * 64'd60 + 64'(secs);
        acc = acc * 64'd1000 + 64'(msecs);
        return acc[TIME_W-1:0];
    endfunction

    function automatic logic is_blank(input logic [CHAR_W-1:0] c);
        return c == CH_SPACE || c == CH_TAB;
    endfunction

    function automatic logic is_digit(input logic [CHAR_W-1:0] c);
        return c >= CH_ZERO && c <= CH_NINE;
    endfunction

    function automatic void feed_char(input logic [CHAR_W-1:0] c);
        logic    in_end;
        t_phase  base;
        t_status st;
        int      rel;
        logic [3:0] dv;
        if (first_status != ST_OK) return;
        dv = 4'(c - CH_ZERO);
        if (cur_phase <= PH_MS || (cur_phase >= PH_E_LEAD && cur_phase <= PH_E_MS)) begin
            in_end = cur_phase >= PH_E_LEAD;
            base   = in_end ? PH_E_LEAD : PH_LEAD;
            st     = in_end ? ST_BAD_END : ST_BAD_START;
            rel    = cur_phase - base;
            case (rel)
                PH_LEAD: begin
                    if (is_blank(c)) return;
                    if (!is_digit(c)) begin
                        note_error(st, DT_HOURS);
                        return;
                    end
                    hrs       = 20'(dv);
                    mins      = '0;
                    secs      = '0;
                    msecs     = '0;
                    digit_cnt = 3'd1;
                    cur_phase = t_phase'(base + PH_HOURS);
                end
                PH_HOURS: begin
                    if (is_digit(c) && digit_cnt < STLP_HOUR_DIGITS) begin
                        hrs       = hrs * 20'd10 + 20'(dv);
                        digit_cnt = digit_cnt + 3'd1;
                    end else if (c == CH_COLON) begin
                        digit_cnt = '0;
                        cur_phase = t_phase'(base + PH_MIN);
                    end else begin
                        note_error(st, DT_COLON1);
                    end
                end
                PH_MIN, PH_SEC: begin
                    if (!is_digit(c)) begin
                        note_error(st, (rel == PH_MIN) ? DT_MIN : DT_SEC);
                        return;
                    end
                    if (rel == PH_MIN) mins = mins * 7'd10 + 7'(dv);
                    else secs = secs * 7'd10 + 7'(dv);
                    digit_cnt = digit_cnt + 3'd1;
                    if (digit_cnt >= 3'd2) begin
                        digit_cnt = '0;
                        cur_phase = t_phase'(base + rel + 1);
                    end
                end
                PH_COLON2: begin
                    if (c == CH_COLON) cur_phase = t_phase'(base + PH_SEC);
                    else note_error(st, DT_COLON2);
                end
                PH_SEP: begin
                    if (c == CH_COMMA || c == CH_DOT) begin
                        digit_cnt = '0;
                        cur_phase = t_phase'(base + PH_MS);
                    end else begin
                        note_error(st, DT_SEP);
                    end
                end
                default: begin
                    if (!is_digit(c)) begin
                        note_error(st, DT_MS);
                        return;
                    end
                    msecs     = msecs * 10'd10 + 10'(dv);
                    digit_cnt = digit_cnt + 3'd1;
                    if (digit_cnt >= 3'd3) begin
                        digit_cnt = '0;
                        if (in_end) begin
                            cur_phase = PH_TRAIL;
                        end else begin
                            start_total_ms = line_total_ms();
                            cur_phase      = PH_ARROW_BLANK;
                        end
                    end
                end
            endcase
            return;
        end
        case (cur_phase)
            PH_ARROW_BLANK: begin
                if (is_blank(c)) return;
                if (c == CH_DASH) cur_phase = PH_ARROW1;
                else note_error(ST_NO_ARROW, DT_NONE);
            end
            PH_ARROW1: begin
                if (c == CH_DASH) cur_phase = PH_ARROW2;
                else note_error(ST_NO_ARROW, DT_NONE);
            end
            PH_ARROW2: begin
                if (c == CH_GT) cur_phase = PH_E_LEAD;
                else note_error(ST_NO_ARROW, DT_NONE);
            end
            default: begin
                if (!is_blank(c)) note_error(ST_TRAIL, DT_NONE);
            end
        endcase
    endfunction

    function automatic t_result close_line();
        t_result r;
        if (first_status == ST_OK) begin
            if (cur_phase <= PH_MS)
                note_error(ST_BAD_START, t_detail'(DT_HOURS + (cur_phase - PH_LEAD)));
            else if (cur_phase >= PH_E_LEAD && cur_phase <= PH_E_MS)
                note_error(ST_BAD_END, t_detail'(DT_HOURS + (cur_phase - PH_E_LEAD)));
            else if (cur_phase != PH_TRAIL)
                note_error(ST_NO_ARROW, DT_NONE);
        end
        r.status = first_status;
        r.detail = first_detail;
        if (first_status == ST_OK) begin
            r.start_ms = start_total_ms;
            r.end_ms   = line_total_ms();
        end else begin
            r.start_ms = '0;
            r.end_ms   = '0;
        end
        clear_line();
        return r;
    endfunction

    task automatic report_mismatch(input string what, input logic [63:0] got_v,
                                   input logic [63:0] want_v);
        $display("mismatch at %0t: %s got %0d expected %0d", $realtime, what, got_v, want_v);
        fail_count++;
    endtask

    // check the result beat against the oldest prediction, then predict
    always @(posedge i_clk) begin
        t_result got;
        t_result want;
        t_result pred;
        if (i_rst_n) begin
            if (m_axis_tvalid && m_axis_tready) begin
                got = t_result'(m_axis_tdata[$bits(t_result)-1:0]);
                if (timing_results_q.size() == 0) begin
                    report_mismatch("result beat with none pending, status", got.status, 0);
                end else begin
                    want = timing_results_q.pop_front();
                    if (got.start_ms != want.start_ms)
                        report_mismatch("start_ms", got.start_ms, want.start_ms);
                    if (got.end_ms != want.end_ms)
                        report_mismatch("end_ms", got.end_ms, want.end_ms);
                    if (got.status != want.status)
                        report_mismatch("status", got.status, want.status);
                    if (got.detail != want.detail)
                        report_mismatch("detail", got.detail, want.detail);
                end
            end
            if (s_axis_tvalid && s_axis_tready) begin
                if (s_axis_tlast) begin
                    pred = close_line();
                    timing_results_q.insert(timing_results_q.size(), pred);
                end else begin
                    feed_char(s_axis_tdata);
                end
            end
        end
    end

    always @(posedge i_clk) begin
        rx_tick++;
        if (rx_tick % 256 == 0) rx_mode = $urandom_range(0, 3);
        case (rx_mode)
            0:       m_axis_tready <= 1'b1;
            1:       m_axis_tready <= 1'($urandom_range(0, 1));
            2:       m_axis_tready <= ($urandom_range(0, 3) == 0);
            default: m_axis_tready <= (rx_tick % 8) < 3;
        endcase
    end

    always @(posedge i_clk) begin
        if (!i_rst_n || (s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready)) begin
            idle_cycles <= 0;
        end else if (idle_cycles >= IDLE_LIMIT) begin
            $display("CHECKS FAILED");
            $finish;
        end else begin
            idle_cycles <= idle_cycles + 1;
        end
    end

    task automatic send_beat(input logic [CHAR_W-1:0] code, input logic last);
        int gap;
        if (burst_left == 0) begin
            gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
            if (gap > 0) begin
                s_axis_tvalid <= 1'b0;
                repeat (gap) @(posedge i_clk);
            end
            burst_left = $urandom_range(1, 48);
        end
        burst_left--;
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= code;
        s_axis_tlast  <= last;
        @(posedge i_clk);
        while (!s_axis_tready) @(posedge i_clk);
        beats_sent++;
    endtask

    task automatic send_line();
        foreach (line_buf[i]) send_beat(line_buf[i], 1'b0);
        send_beat(CHAR_W'($urandom_range(0, 255)), 1'b1);
    endtask

    task automatic add_char(input logic [CHAR_W-1:0] c);
        line_buf.insert(line_buf.size(), c);
    endtask

    task automatic set_line(input string s);
        line_buf.delete();
        for (int i = 0; i < s.len(); i++) add_char(s[i]);
    endtask

    task automatic append_digits(input int n);
        for (int i = 0; i < n; i++) add_char(CH_ZERO + CHAR_W'($urandom_range(0, 9)));
    endtask

    task automatic append_blanks(input int max_n);
        int n;
        n = $urandom_range(0, max_n);
        for (int i = 0; i < n; i++) add_char($urandom_range(0, 1) ? CH_SPACE : CH_TAB);
    endtask

    task automatic append_time();
        int r;
        r = $urandom_range(0, 7);
        if (r == 0) append_digits(STLP_HOUR_DIGITS);
        else if (r < 5) append_digits($urandom_range(1, 2));
        else append_digits($urandom_range(1, STLP_HOUR_DIGITS));
        add_char(CH_COLON);
        append_digits(2);
        add_char(CH_COLON);
        append_digits(2);
        add_char($urandom_range(0, 1) ? CH_COMMA : CH_DOT);
        append_digits(3);
    endtask

    task automatic build_good_line();
        line_buf.delete();
        append_blanks(3);
        append_time();
        append_blanks(3);
        add_char(CH_DASH);
        add_char(CH_DASH);
        add_char(CH_GT);
        append_blanks(3);
        append_time();
        append_blanks(3);
    endtask

    function automatic logic [CHAR_W-1:0] pick_char();
        case ($urandom_range(0, 7))
            0:       return CH_ZERO + CHAR_W'($urandom_range(0, 9));
            1:       return CH_COLON;
            2:       return $urandom_range(0, 1) ? CH_COMMA : CH_DOT;
            3:       return CH_DASH;
            4:       return CH_GT;
            5:       return $urandom_range(0, 1) ? CH_SPACE : CH_TAB;
            default: return CHAR_W'($urandom_range(0, 255));
        endcase
    endfunction

    task automatic break_line();
        int kind;
        int idx;
        int keep;
        kind = $urandom_range(0, 3);
        if (line_buf.size() == 0) kind = 3;
        idx = $urandom_range(0, line_buf.size() - 1);
        case (kind)
            0: begin
                keep = $urandom_range(0, line_buf.size());
                while (line_buf.size() > keep) void'(line_buf.pop_back());
            end
            1: line_buf[idx] = pick_char();
            2: line_buf.insert(idx, pick_char());
            default: begin
                line_buf.delete();
                keep = $urandom_range(0, 30);
                for (int i = 0; i < keep; i++)
                    add_char(CHAR_W'($urandom_range(0, 255)));
            end
        endcase
    endtask

    task automatic test_directed_lines();
        set_line("0:00:00,000-->0:00:00.000");                      send_line();
        set_line(" \t999999:99:99.999 \t-->\t 999999:99:99,999 \t"); send_line();
        set_line("");                                               send_line();
        set_line("1:3");                                            send_line();
        set_line("1234567");                                        send_line();
        set_line("0:00:00,0000");                                   send_line();
        set_line("0:00:00,000 --> 0:00:00,000 x");                  send_line();
        set_line("0:00:00,000-->0:00:00,0001");                     send_line();
        set_line("0:00:00,000 -");                                  send_line();
        set_line("0:00:00,000-->1:02:03;004");                      send_line();
        set_line("a");                                              send_line();
        set_line("0:00:00,000-->");                                 send_line();
    endtask

    task automatic test_wellformed_lines();
        while (beats_sent < GOOD_BEATS) begin
            build_good_line();
            if ($urandom_range(0, 9) == 0) break_line();
            send_line();
        end
    endtask

    task automatic test_broken_lines();
        while (beats_sent < TOTAL_BEATS) begin
            build_good_line();
            if ($urandom_range(0, 3) != 0) break_line();
            send_line();
        end
    endtask

    initial begin
        int waited;
        clear_line();
        repeat (2) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);
        test_directed_lines();
        test_wellformed_lines();
        test_broken_lines();
        s_axis_tvalid <= 1'b0;
        while (timing_results_q.size() != 0) @(posedge i_clk);
        waited = 0;
        while (waited < DRAIN_WAIT) begin
            @(posedge i_clk);
            waited++;
        end
        if (fail_count == 0) begin
            $display("ALL CHECKS PASSED");
        end else begin
            $display("CHECKS FAILED");
        end
        $finish;
    end

endmodule
